### rtl/anbd_pkg.sv
package anbd_pkg;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_END     = 2'd1,
        KIND_DISCARD = 2'd2
    } kind_t;

    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_START = 8'h01;
    localparam logic [7:0] BYTE_EPB   = 8'h03;
    localparam logic [1:0] HELD_MAX   = 2'd3;
    localparam logic [1:0] HELD_CODE  = 2'd2;

    // one classified input byte: a run of held zeros, then an optional tail result
    typedef struct packed {
        logic [1:0]  zcnt;
        kind_t       zkind;
        logic        tail_en;
        kind_t       tail_kind;
        logic [7:0]  tail_byte;
        logic [15:0] unit;
    } cmd_t;

endpackage

### rtl/anbd_front.sv
module anbd_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  logic [7:0]        in_byte,
    input  logic              is_flush,
    output logic              push,
    output anbd_pkg::cmd_t    cmd
);

    logic [1:0]  held_reg, held_next;
    logic        inside_reg, inside_next;
    logic [15:0] unit_reg, unit_next;
    anbd_pkg::kind_t data_kind;

    assign data_kind = inside_reg ? anbd_pkg::KIND_PAYLOAD : anbd_pkg::KIND_DISCARD;

    always_comb begin
        held_next      = held_reg;
        inside_next    = inside_reg;
        unit_next      = unit_reg;
        cmd.zcnt       = 2'd0;
        cmd.zkind      = data_kind;
        cmd.tail_en    = 1'b0;
        cmd.tail_kind  = data_kind;
        cmd.tail_byte  = anbd_pkg::BYTE_ZERO;
        cmd.unit       = unit_reg;
        priority if (is_flush) begin
            cmd.zcnt      = held_reg;
            cmd.tail_en   = inside_reg;
            cmd.tail_kind = anbd_pkg::KIND_END;
            held_next     = 2'd0;
            inside_next   = 1'b0;
            unit_next     = unit_reg + {15'd0, inside_reg};
        end else if (in_byte == anbd_pkg::BYTE_ZERO) begin
            // oldest zero falls out once three are held
            if (held_reg == anbd_pkg::HELD_MAX) begin
                cmd.zcnt = 2'd1;
            end else begin
                held_next = held_reg + 2'd1;
            end
        end else if (in_byte == anbd_pkg::BYTE_START && held_reg >= anbd_pkg::HELD_CODE) begin
            cmd.tail_en   = inside_reg;
            cmd.tail_kind = anbd_pkg::KIND_END;
            held_next     = 2'd0;
            inside_next   = 1'b1;
            unit_next     = unit_reg + {15'd0, inside_reg};
        end else if (in_byte == anbd_pkg::BYTE_EPB && held_reg >= anbd_pkg::HELD_CODE) begin
            cmd.zcnt      = held_reg;
            cmd.tail_en   = !inside_reg;
            cmd.tail_kind = anbd_pkg::KIND_DISCARD;
            cmd.tail_byte = anbd_pkg::BYTE_EPB;
            held_next     = 2'd0;
        end else begin
            cmd.zcnt      = held_reg;
            cmd.tail_en   = 1'b1;
            cmd.tail_byte = in_byte;
            held_next     = 2'd0;
        end
    end

    assign push = take && (cmd.zcnt != 2'd0 || cmd.tail_en);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg   <= 2'd0;
            inside_reg <= 1'b0;
            unit_reg   <= 16'd0;
        end else if (take) begin
            held_reg   <= held_next;
            inside_reg <= inside_next;
            unit_reg   <= unit_next;
        end
    end

endmodule

### rtl/anbd_queue.sv
module anbd_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  anbd_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output anbd_pkg::cmd_t    head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    anbd_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)      count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### rtl/anbd_back.sv
module anbd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              head_valid,
    input  anbd_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg;
    logic [7:0]  byte_reg, byte_next;
    logic [15:0] unit_reg;
    anbd_pkg::kind_t kind_reg, kind_next;
    logic        last_reg, last_next;
    logic [2:0]  total;
    logic        load;

    assign total = {1'b0, head_cmd.zcnt} + {2'b0, head_cmd.tail_en};
    assign load  = head_valid && (!valid_reg || m_tready);

    always_comb begin
        last_next = ({1'b0, idx_reg} + 3'd1) == total;
        if (idx_reg < head_cmd.zcnt) begin
            kind_next = head_cmd.zkind;
            byte_next = anbd_pkg::BYTE_ZERO;
        end else begin
            kind_next = head_cmd.tail_kind;
            byte_next = head_cmd.tail_byte;
        end
        idx_next = last_next ? 2'd0 : idx_reg + 2'd1;
    end

    assign pop = load && last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= idx_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg <= kind_next;
            byte_reg <= byte_next;
            unit_reg <= head_cmd.unit;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {unit_reg, byte_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

### rtl/annexb_nal_deframer_unit.sv
// the first result beat of a byte is registered in the command queue, then in the output register
// throughput: one byte per cycle while the queue has space; a byte that yields k results sends k result beats
// bytes that yield no result (held zeros, start codes with no open unit) free output slots for bursts
// the command queue between front end and output stage absorbs bursts of up to QUEUE_DEPTH bytes
// reset: aresetn synchronous, active low; clears held zeros, open unit flag, unit count and queue
module annexb_nal_deframer_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input beat channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // [0] is_flush
    // result beat channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] unit_number
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // last_of_run
);

    logic           take;
    logic           push;
    logic           full;
    logic           pop;
    logic           head_valid;
    anbd_pkg::cmd_t push_cmd;
    anbd_pkg::cmd_t head_cmd;

    // the front end never waits on the output, only on queue space
    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    // classifies each byte against held zeros and tracks the open unit
    anbd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .in_byte  (s_tdata),
        .is_flush (s_tuser),
        .push     (push),
        .cmd      (push_cmd)
    );

    // only bytes that produce at least one result enter the queue
    anbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // expands each queued command into its result beats behind an output register
    anbd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

### rtl/anbd_checker.sv
module anbd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // no results straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // stalled beat keeps its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled beat changed");

    // end marker carries a zero byte and closes the run
    a_end_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == anbd_pkg::KIND_END |-> m_tdata[7:0] == 8'h00 && m_tlast)
        else $error("bad end marker");

    // unit number only moves on after a run has ended
    a_unit_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast ##1 m_tvalid |-> $stable(m_tdata[23:8]))
        else $error("unit number changed inside a run");

endmodule

bind annexb_nal_deframer_unit anbd_checker u_anbd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
